// ===== src/vld_pkg.sv =====
// Package for the varint length message deframer.
// Holds widths, constants and the state and result structs; no dependencies.
package vld_pkg;

	localparam int MAX_PREFIX_BYTES = 5;
	localparam int LEN_BITS = 35;
	localparam int DIGIT_BITS = 7;
	localparam int PIDX_W = (MAX_PREFIX_BYTES > 1) ? $clog2(MAX_PREFIX_BYTES) : 1;
	localparam int SHIFT_W = $clog2(DIGIT_BITS * MAX_PREFIX_BYTES);
	localparam int WIDE_W = LEN_BITS + DIGIT_BITS;

	localparam logic [7:0] HS_TERM = 8'h1E;
	localparam logic [PIDX_W-1:0] LAST_PIDX = PIDX_W'(MAX_PREFIX_BYTES - 1);

	typedef logic [LEN_BITS-1:0] len_t;
	typedef logic [PIDX_W-1:0] pidx_t;

	typedef struct packed {
		logic  hs_done;
		pidx_t prefix_idx;
		len_t  len_acc;
		len_t  remaining;
	} vld_state_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_handshake;
		logic       in_prefix;
		logic       prefix_done;
		len_t       payload_length;
		logic       msg_last;
	} vld_result_t;

endpackage

// ===== src/vld_in_if.sv =====
// Byte channel into the deframer: valid, ready and one received byte.
// Depends on vld_pkg.
interface vld_in_if import vld_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

// ===== src/vld_out_if.sv =====
// Result channel of the deframer: valid, ready, the byte and its framing flags.
// Depends on vld_pkg for the length type.
interface vld_out_if import vld_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       is_handshake;
	logic       in_prefix;
	logic       prefix_done;
	len_t       payload_length;
	logic       msg_last;

	modport source (output valid, output out_byte, output is_handshake, output in_prefix,
		output prefix_done, output payload_length, output msg_last, input ready);
	modport sink (input valid, input out_byte, input is_handshake, input in_prefix,
		input prefix_done, input payload_length, input msg_last, output ready);
endinterface

// ===== src/vld_step.sv =====
// Per-byte framing logic: next state and result flags for one received byte.
// Depends on vld_pkg.
module vld_step import vld_pkg::*; (
	input  vld_state_t  cur,
	input  logic [7:0]  data_byte,
	output vld_state_t  nxt,
	output vld_result_t res
);

	logic [SHIFT_W-1:0] shift;
	logic [WIDE_W-1:0]  digit_wide;
	len_t               acc_new;
	len_t               rem_dec;
	logic               prefix_end;

	always_comb begin
		shift = SHIFT_W'(cur.prefix_idx) * SHIFT_W'(DIGIT_BITS);
		digit_wide = WIDE_W'(data_byte[6:0]) << shift;
		acc_new = cur.len_acc | digit_wide[LEN_BITS-1:0];
		rem_dec = cur.remaining - len_t'(1);
		prefix_end = !data_byte[7] || (cur.prefix_idx == LAST_PIDX);

		nxt = cur;
		res.out_byte = data_byte;
		res.is_handshake = 1'b0;
		res.in_prefix = 1'b0;
		res.prefix_done = 1'b0;
		res.payload_length = '0;
		res.msg_last = 1'b0;

		if (!cur.hs_done) begin
			res.is_handshake = 1'b1;
			if (data_byte == HS_TERM) begin
				res.msg_last = 1'b1;
				nxt.hs_done = 1'b1;
			end
		end else if (cur.remaining == '0) begin
			res.in_prefix = 1'b1;
			if (prefix_end) begin
				res.prefix_done = 1'b1;
				res.payload_length = acc_new;
				res.msg_last = (acc_new == '0);
				nxt.remaining = acc_new;
				nxt.len_acc = '0;
				nxt.prefix_idx = '0;
			end else begin
				nxt.len_acc = acc_new;
				nxt.prefix_idx = cur.prefix_idx + pidx_t'(1);
			end
		end else begin
			nxt.remaining = rem_dec;
			res.msg_last = (rem_dec == '0);
		end
	end

endmodule

// ===== src/varint_length_message_deframer.sv =====
// Varint length message deframer.
// Marks handshake, length prefix and message boundaries in a received byte stream.
// Depends on vld_pkg, vld_in_if, vld_out_if and vld_step.
//
// Usage:
//   stream: one received byte per transfer (valid/ready, data_byte).
//   result: one transfer per byte: the byte, is_handshake, in_prefix, prefix_done,
//     payload_length (nonzero only with prefix_done) and msg_last.
//   Bytes up to and including the first 0x1E form the handshake record; after
//   that each message is a 1 to 5 byte little-endian base-128 length prefix
//   followed by that many payload bytes. A zero length ends the message on
//   the last prefix byte.
//   Path: an accepted byte is held in the input register, and its result
//   then in the result register.
//   Throughput: one byte per cycle while result is taken; the framing state
//   updates in the single stage between the two registers.
//   Reset: arst_n clears the framing state, so the next byte opens a handshake;
//   both pipeline stages empty.
//   Stall: while result is not taken, the result register holds, the input
//   register fills, and then stream.ready drops; nothing is lost.
module varint_length_message_deframer import vld_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	vld_in_if.sink    stream,
	vld_out_if.source result
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        out_valid_q;
	vld_result_t out_q;
	vld_state_t  state_q;
	vld_state_t  state_nxt;
	vld_result_t step_res;
	logic        advance;

	assign advance = !out_valid_q || result.ready;
	assign stream.ready = !valid_s1 || advance;

	vld_step u_step (
		.cur       (state_q),
		.data_byte (byte_s1),
		.nxt       (state_nxt),
		.res       (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			state_q <= '0;
		end else begin
			if (stream.ready) begin
				valid_s1 <= stream.valid;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
				if (valid_s1) begin
					state_q <= state_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (stream.ready && stream.valid) begin
			byte_s1 <= stream.data_byte;
		end
		if (advance && valid_s1) begin
			out_q <= step_res;
		end
	end

	assign result.valid = out_valid_q;
	assign result.out_byte = out_q.out_byte;
	assign result.is_handshake = out_q.is_handshake;
	assign result.in_prefix = out_q.in_prefix;
	assign result.prefix_done = out_q.prefix_done;
	assign result.payload_length = out_q.payload_length;
	assign result.msg_last = out_q.msg_last;

	a_hs_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.hs_done |=> state_q.hs_done)
		else $error("handshake flag cleared after completion");

	a_payload_idle_acc: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.remaining != '0) |-> (state_q.len_acc == '0 && state_q.prefix_idx == '0))
		else $error("prefix accumulator busy during payload");

	a_len_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.prefix_done) |-> (out_q.payload_length == '0))
		else $error("payload length without prefix end");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_q.is_handshake && out_q.in_prefix))
		else $error("byte marked as handshake and prefix");

	a_no_state_move: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |=> $stable(state_q))
		else $error("framing state moved without a byte");

endmodule
